// ===== rtl/rdf_pkg.sv =====
// Shared types, codes and CRC function of the register datagram framer.
`default_nettype none

package rdf_pkg;

  localparam int unsigned FrameBytes = 7;
  localparam int unsigned CntW       = 3;

  localparam logic [7:0] SyncByte  = 8'h05;
  localparam logic [7:0] CrcPoly   = 8'h07;
  localparam logic [7:0] WriteFlag = 8'h80;
  localparam logic [2:0] ReplyLast = 3'd7;
  localparam logic [2:0] ValueFrom = 3'd3;
  localparam logic [2:0] WriteCnt  = 3'd7;
  localparam logic [2:0] ReadCnt   = 3'd3;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_REPLY = 2'd2
  } opcode_e;

  typedef enum logic {
    KIND_TX    = 1'b0,
    KIND_REPLY = 1'b1
  } kind_e;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
    logic        status;
  } reply_res_t;

  typedef logic [7:0] byte_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    logic       fb;
    crc = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[7] ^ data[i];
      crc = {crc[6:0], 1'b0};
      if (fb) begin
        crc = crc ^ CrcPoly;
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rdf_if.sv =====
// Valid/ready channel interfaces for commands and results.
`default_nettype none

interface rdf_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [1:0]  node_addr;
  logic [6:0]  reg_num;
  logic [31:0] write_value;
  logic [7:0]  rx_byte;

  modport source (output valid, opcode, node_addr, reg_num, write_value, rx_byte,
                  input ready);
  modport sink (input valid, opcode, node_addr, reg_num, write_value, rx_byte,
                output ready);
endinterface

interface rdf_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [31:0] read_value;
  logic        read_status;

  modport source (output valid, kind, tx_byte, last, read_value, read_status,
                  input ready);
  modport sink (input valid, kind, tx_byte, last, read_value, read_status,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/rdf_reply.sv =====
// Reply tracker: running CRC, byte count and value assembly for read replies.
`default_nettype none

module rdf_reply
  import rdf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       acc_i,
  input  wire logic [1:0] opcode_i,
  input  wire logic [7:0] rx_byte_i,
  output reply_res_t      res_o
);

  logic [2:0]  count_q, count_d;
  logic [7:0]  crc_q, crc_d;
  logic [31:0] value_q, value_d;

  always_comb begin
    count_d      = count_q;
    crc_d        = crc_q;
    value_d      = value_q;
    res_o.done   = 1'b0;
    res_o.value  = value_q;
    res_o.status = (crc_q != rx_byte_i);
    if (acc_i) begin
      case (opcode_i)
        OP_READ: begin
          count_d = '0;
          crc_d   = '0;
          value_d = '0;
        end
        OP_REPLY: begin
          if (count_q == ReplyLast) begin
            res_o.done = 1'b1;
            count_d    = '0;
            crc_d      = '0;
            value_d    = '0;
          end else begin
            crc_d   = crc_byte(crc_q, rx_byte_i);
            count_d = count_q + 3'd1;
            if (count_q >= ValueFrom) begin
              value_d = {value_q[23:0], rx_byte_i};
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      crc_q   <= '0;
      value_q <= '0;
    end else begin
      count_q <= count_d;
      crc_q   <= crc_d;
      value_q <= value_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rdf_emit.sv =====
// Result engine: loads a datagram or reply result and emits it one item per cycle while res_o is ready.
`default_nettype none

module rdf_emit
  import rdf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        acc_i,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [1:0]  node_addr_i,
  input  wire logic [6:0]  reg_num_i,
  input  wire logic [31:0] write_value_i,
  input  wire reply_res_t  reply_i,
  output logic             load_ready_o,
  rdf_res_if.source        res_o
);

  byte_t           bytes_q [FrameBytes];
  byte_t           bytes_d [FrameBytes];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      crc_q, crc_d;
  logic            active_q, active_d;
  logic            kind_q, kind_d;
  logic [31:0]     value_q, value_d;
  logic            status_q, status_d;
  logic            is_last;
  logic            take;
  logic            load;

  assign is_last      = (cnt_q == '0);
  assign take         = active_q && res_o.ready;
  assign load_ready_o = !active_q || (res_o.ready && is_last);

  assign res_o.valid       = active_q;
  assign res_o.kind        = kind_q;
  assign res_o.last        = is_last;
  assign res_o.tx_byte     = (kind_q == KIND_REPLY) ? 8'h00 :
                             (is_last ? crc_q : bytes_q[0]);
  assign res_o.read_value  = value_q;
  assign res_o.read_status = status_q;

  always_comb begin
    load = 1'b0;
    if (acc_i) begin
      case (opcode_i)
        OP_WRITE, OP_READ: load = 1'b1;
        OP_REPLY:          load = reply_i.done;
        default:           load = 1'b0;
      endcase
    end
  end

  always_comb begin
    bytes_d  = bytes_q;
    cnt_d    = cnt_q;
    crc_d    = crc_q;
    active_d = active_q;
    kind_d   = kind_q;
    value_d  = value_q;
    status_d = status_q;
    if (take) begin
      if (is_last) begin
        active_d = 1'b0;
      end else begin
        for (int i = 0; i < FrameBytes - 1; i++) begin
          bytes_d[i] = bytes_q[i+1];
        end
        bytes_d[FrameBytes-1] = 8'h00;
        cnt_d = cnt_q - 1'b1;
        crc_d = crc_byte(crc_q, bytes_q[0]);
      end
    end
    if (load) begin
      active_d = 1'b1;
      crc_d    = '0;
      for (int i = 0; i < FrameBytes; i++) begin
        bytes_d[i] = 8'h00;
      end
      bytes_d[0] = SyncByte;
      bytes_d[1] = {6'd0, node_addr_i};
      if (opcode_i == OP_REPLY) begin
        kind_d   = KIND_REPLY;
        cnt_d    = '0;
        value_d  = reply_i.value;
        status_d = reply_i.status;
      end else begin
        kind_d   = KIND_TX;
        value_d  = '0;
        status_d = 1'b0;
        if (opcode_i == OP_WRITE) begin
          cnt_d      = WriteCnt;
          bytes_d[2] = WriteFlag | {1'b0, reg_num_i};
          bytes_d[3] = write_value_i[31:24];
          bytes_d[4] = write_value_i[23:16];
          bytes_d[5] = write_value_i[15:8];
          bytes_d[6] = write_value_i[7:0];
        end else begin
          cnt_d      = ReadCnt;
          bytes_d[2] = {1'b0, reg_num_i};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q  <= bytes_d;
    crc_q    <= crc_d;
    kind_q   <= kind_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

endmodule

`default_nettype wire

// ===== rtl/register_datagram_framer.sv =====
// Top level of the register datagram framer and reply deframer.
//
//   channel | dir | payload                                              | handshake
//   cmd_i   | in  | opcode, node_addr, reg_num, write_value, rx_byte      | valid/ready
//   res_o   | out | kind, tx_byte, last, read_value, read_status         | valid/ready
//
// A write command gives 8 result items, a read command 4, one per cycle while
// res_o is ready; a completed reply gives 1 and other reply bytes none. The next
// command is taken in the cycle the last item of the current one leaves the result
// register. The result register and its byte shift line set the rate. Reset clears
// the reply tracker and empties the result register. A stalled result holds
// the command input until its last item is taken.
`default_nettype none

module register_datagram_framer
  import rdf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rdf_cmd_if.sink   cmd_i,
  rdf_res_if.source res_o
);

  logic       acc;
  logic       load_ready;
  reply_res_t reply_res;

  assign cmd_i.ready = load_ready;
  assign acc         = cmd_i.valid && load_ready;

  rdf_reply u_reply (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .opcode_i  (cmd_i.opcode),
    .rx_byte_i (cmd_i.rx_byte),
    .res_o     (reply_res)
  );

  rdf_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .acc_i         (acc),
    .opcode_i      (cmd_i.opcode),
    .node_addr_i   (cmd_i.node_addr),
    .reg_num_i     (cmd_i.reg_num),
    .write_value_i (cmd_i.write_value),
    .reply_i       (reply_res),
    .load_ready_o  (load_ready),
    .res_o         (res_o)
  );

endmodule

`default_nettype wire

// ===== test/register_datagram_framer_test.sv =====
// Testbench of the register datagram framer: directed table and random commands checked by a predictor.
`timescale 1ns / 100ps

module register_datagram_framer_test;
  import rdf_pkg::*;

  localparam logic [1:0] OpUnused    = 2'd3;
  localparam int         NumDirected = 25;
  localparam int         NumRandom   = 200;
  localparam int         QuietFrom   = 60;
  localparam int         QuietTo     = 110;
  localparam int         HoldStart   = 300;
  localparam int         HoldLen     = 100;
  localparam int         StallLimit  = 1000;
  localparam int         DrainCycles = 16;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  slave;
    logic [6:0]  regno;
    logic [31:0] wval;
    logic [7:0]  rx;
    logic        typed;
    logic [31:0] typed_value;
    logic        typed_status;
  } cmd_item_t;

  typedef struct packed {
    kind_e       kind;
    byte_t       tx;
    logic        last;
    logic [31:0] value;
    logic        status;
  } res_item_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  rdf_cmd_if cmd_if ();
  rdf_res_if res_if ();

  register_datagram_framer u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Reply tracker of the predictor and the bus bytes and replies it expects.
  logic [2:0]  trk_count = '0;
  byte_t       trk_crc   = '0;
  logic [31:0] trk_value = '0;
  res_item_t   framed_q[$];

  cmd_item_t   stim_q[$];
  cmd_item_t   cur_item;
  int          n_queued    = 0;
  int          err_cnt     = 0;
  int          idle_cycles = 0;
  int          n_cmds      = 0;
  int          n_ignored   = 0;
  int          n_tx        = 0;
  int          n_replies   = 0;
  int          n_bad_crc   = 0;

  // Reply completions after reset and after a finished reply carry their result in the row.
  cmd_item_t dir_tbl [NumDirected] = '{
    '{OP_REPLY, 2'd0, 7'h00, 32'h0000_0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_REPLY, 2'd0, 7'h00, 32'h0000_0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_REPLY, 2'd0, 7'h00, 32'h0000_0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_REPLY, 2'd0, 7'h00, 32'h0000_0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_REPLY, 2'd0, 7'h00, 32'h0000_0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_REPLY, 2'd0, 7'h00, 32'h0000_0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_REPLY, 2'd0, 7'h00, 32'h0000_0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_REPLY, 2'd0, 7'h00, 32'h0000_0000, 8'h00, 1'b1, 32'd0, 1'b0},
    '{OP_REPLY, 2'd0, 7'h00, 32'h0000_0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_REPLY, 2'd0, 7'h00, 32'h0000_0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_REPLY, 2'd0, 7'h00, 32'h0000_0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_REPLY, 2'd0, 7'h00, 32'h0000_0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_REPLY, 2'd0, 7'h00, 32'h0000_0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_REPLY, 2'd0, 7'h00, 32'h0000_0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_REPLY, 2'd0, 7'h00, 32'h0000_0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_REPLY, 2'd0, 7'h00, 32'h0000_0000, 8'hFF, 1'b1, 32'd0, 1'b1},
    '{OP_WRITE, 2'd3, 7'h7F, 32'hFFFF_FFFF, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_WRITE, 2'd0, 7'h00, 32'h0000_0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_READ,  2'd3, 7'h7F, 32'h0000_0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_READ,  2'd0, 7'h00, 32'h0000_0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_REPLY, 2'd0, 7'h00, 32'h0000_0000, 8'hA5, 1'b0, 32'd0, 1'b0},
    '{OpUnused, 2'd3, 7'h7F, 32'hFFFF_FFFF, 8'hFF, 1'b0, 32'd0, 1'b0},
    '{OP_WRITE, 2'd1, 7'h2A, 32'h1234_5678, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_REPLY, 2'd0, 7'h00, 32'h0000_0000, 8'h5A, 1'b0, 32'd0, 1'b0},
    '{OP_READ,  2'd2, 7'h55, 32'h0000_0000, 8'h00, 1'b0, 32'd0, 1'b0}
  };

  function automatic byte_t crc8_lsb(input byte_t crc_in, input byte_t data);
    byte_t crc;
    logic  fb;
    crc = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[7] ^ data[i];
      crc = {crc[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return crc;
  endfunction

  function automatic cmd_item_t rand_item(input logic [1:0] op);
    cmd_item_t c;
    c       = '0;
    c.op    = op;
    c.slave = 2'($urandom);
    c.regno = 7'($urandom);
    c.wval  = $urandom();
    c.rx    = 8'($urandom);
    return c;
  endfunction

  task automatic queue_item(input cmd_item_t c);
    stim_q.push_back(c);
    if (c.op != OpUnused) begin
      n_queued++;
    end
  endtask

  task automatic clear_tracker();
    trk_count = '0;
    trk_crc   = '0;
    trk_value = '0;
  endtask

  task automatic frame_command(input cmd_item_t c);
    byte_t     frame [8];
    byte_t     crc;
    int        n;
    res_item_t r;
    if (c.op == OP_WRITE || c.op == OP_READ) begin
      frame[0] = SyncByte;
      frame[1] = {6'd0, c.slave};
      if (c.op == OP_WRITE) begin
        frame[2] = WriteFlag | {1'b0, c.regno};
        frame[3] = c.wval[31:24];
        frame[4] = c.wval[23:16];
        frame[5] = c.wval[15:8];
        frame[6] = c.wval[7:0];
        n = 8;
      end else begin
        frame[2] = {1'b0, c.regno};
        n = 4;
        clear_tracker();
      end
      crc = '0;
      for (int i = 0; i < n - 1; i++) begin
        crc = crc8_lsb(crc, frame[i]);
      end
      frame[n - 1] = crc;
      for (int i = 0; i < n; i++) begin
        framed_q.push_back('{KIND_TX, frame[i], i == n - 1, 32'd0, 1'b0});
      end
    end else if (c.op == OP_REPLY) begin
      if (trk_count != ReplyLast) begin
        trk_crc = crc8_lsb(trk_crc, c.rx);
        if (trk_count >= ValueFrom) begin
          trk_value = {trk_value[23:0], c.rx};
        end
        trk_count++;
      end else begin
        r = '{KIND_REPLY, 8'd0, 1'b1, trk_value, trk_crc != c.rx};
        if (c.typed) begin
          r.value  = c.typed_value;
          r.status = c.typed_status;
        end
        framed_q.push_back(r);
        clear_tracker();
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v, input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin : monitor
    res_item_t want;
    logic      moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cmd_if.valid && cmd_if.ready) begin
        moved = 1'b1;
        frame_command(cur_item);
        if (cur_item.op == OpUnused) begin
          n_ignored++;
        end else begin
          n_cmds++;
        end
      end
      if (res_if.valid && res_if.ready) begin
        moved = 1'b1;
        if (framed_q.size() == 0) begin
          $error("result item with nothing expected: kind %0d tx_byte %0h",
                 res_if.kind, res_if.tx_byte);
          err_cnt++;
        end else begin
          want = framed_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(res_if.kind));
          check_field("tx_byte", 32'(want.tx), 32'(res_if.tx_byte));
          check_field("last", 32'(want.last), 32'(res_if.last));
          check_field("read_value", want.value, res_if.read_value);
          check_field("read_status", 32'(want.status), 32'(res_if.read_status));
          if (want.kind == KIND_TX) begin
            n_tx++;
          end else begin
            n_replies++;
            if (want.status) begin
              n_bad_crc++;
            end
          end
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  initial begin : watchdog
    wait (idle_cycles >= StallLimit);
    $display("DONE: errors detected");
    $finish;
  end

  // Stall on a rolling pattern, flow freely now and then, and hold off once for a long stretch.
  initial begin : receiver
    logic [15:0] pattern;
    logic        flowing;
    int          cyc;
    res_if.ready <= 1'b0;
    pattern = 16'hFFFF;
    flowing = 1'b1;
    cyc     = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (cyc % 64 == 0) begin
        flowing = ($urandom_range(0, 3) == 0);
        pattern = 16'($urandom) | 16'h0101;
      end
      if (cyc >= HoldStart && cyc < HoldStart + HoldLen) begin
        res_if.ready <= 1'b0;
      end else if (flowing) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= pattern[cyc % 16];
      end
      cyc++;
    end
  end

  initial begin : stimulus
    cmd_item_t c;
    byte_t     crc;
    int        pick;
    int        gap;
    int        burst_left;
    cmd_if.valid       <= 1'b0;
    cmd_if.opcode      <= '0;
    cmd_if.node_addr   <= '0;
    cmd_if.reg_num     <= '0;
    cmd_if.write_value <= '0;
    cmd_if.rx_byte     <= '0;
    cur_item           <= '0;

    foreach (dir_tbl[i]) begin
      queue_item(dir_tbl[i]);
    end
    n_queued = 0;

    // Mostly read request plus eight reply bytes, some writes, some noise and cut replies.
    while (n_queued < NumRandom) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        queue_item(rand_item(OP_READ));
        crc = '0;
        for (int k = 0; k < 7; k++) begin
          c = rand_item(OP_REPLY);
          crc = crc8_lsb(crc, c.rx);
          queue_item(c);
          if ($urandom_range(0, 9) == 0) begin
            queue_item(rand_item(OP_WRITE));
          end
          if ($urandom_range(0, 19) == 0) begin
            queue_item(rand_item(OpUnused));
          end
        end
        c = rand_item(OP_REPLY);
        c.rx = ($urandom_range(0, 7) == 0) ? crc ^ 8'($urandom_range(1, 255)) : crc;
        queue_item(c);
      end else if (pick < 8) begin
        queue_item(rand_item(OP_WRITE));
      end else if (pick == 8) begin
        queue_item(rand_item(2'($urandom_range(0, 3))));
      end else begin
        repeat ($urandom_range(1, 6)) queue_item(rand_item(OP_REPLY));
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    burst_left = 0;
    foreach (stim_q[i]) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = (i >= QuietFrom && i < QuietTo) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          cmd_if.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      cmd_if.valid       <= 1'b1;
      cmd_if.opcode      <= stim_q[i].op;
      cmd_if.node_addr   <= stim_q[i].slave;
      cmd_if.reg_num     <= stim_q[i].regno;
      cmd_if.write_value <= stim_q[i].wval;
      cmd_if.rx_byte     <= stim_q[i].rx;
      cur_item           <= stim_q[i];
      @(posedge clk);
      while (!cmd_if.ready) @(posedge clk);
      burst_left--;
    end
    cmd_if.valid <= 1'b0;
    @(posedge clk);

    while (framed_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d commands and %0d unused opcodes; checked %0d bus bytes and %0d replies.",
             n_cmds, n_ignored, n_tx, n_replies);
    $display("Replies with CRC mismatch: %0d; receiver held off %0d cycles once.",
             n_bad_crc, HoldLen);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
